>>> sv/tls_client_hello_sni_extractor_top_defines.svh
// Assertion macros shared by the SNI extractor RTL.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TCSE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold whenever its antecedent holds.
`define TCSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/tcse_pkg.sv
// Package with types, constants and helpers of the SNI extractor.
package tcse_pkg;

    // Default parameter values.
    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Width of intermediate sums of positions and lengths.
    localparam int SUM_BITS = 18;

    // Protocol constants.
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  VER_MAJOR       = 8'h03;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0]  NAME_HOST       = 8'h00;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam int          POS_REC_TYPE    = 0;
    localparam int          POS_VER_MAJOR   = 1;
    localparam int          POS_HS_TYPE     = 5;
    localparam int          HDR_MIN_LEN     = 43;
    localparam int          HDR_LAST_POS    = 42;

    // Result kinds.
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR   = 4'd1,
        PH_SID   = 4'd2,
        PH_CS_HI = 4'd3,
        PH_CS_LO = 4'd4,
        PH_COMP  = 4'd5,
        PH_ET_HI = 4'd6,
        PH_ET_LO = 4'd7,
        PH_X_T0  = 4'd8,
        PH_X_T1  = 4'd9,
        PH_X_L0  = 4'd10,
        PH_X_L1  = 4'd11,
        PH_SNI   = 4'd12,
        PH_NAME  = 4'd13,
        PH_DONE  = 4'd14
    } t_phase;

    // Work passed from the parser to the output side for one input byte.
    typedef struct packed {
        logic        name_vld;
        logic [7:0]  name_byte;
        logic        name_last;
        logic        verd_vld;
        logic        verd_found;
        logic [15:0] host_len;
    } t_entry;

    // True when another extension header starts at least five bytes before the end.
    function automatic logic ext_fits(input logic [15:0] pos, input logic [15:0] count,
                                      input logic [15:0] ext_end);
        return (SUM_BITS'(pos) + SUM_BITS'(5) + SUM_BITS'(count)) < SUM_BITS'(ext_end);
    endfunction

endpackage

>>> sv/tcse_front.sv
// Front end: accepts payload bytes and walks the ClientHello structure.
`include "tls_client_hello_sni_extractor_top_defines.svh"
module tcse_front #(
    parameter int LENGTH_BITS = tcse_pkg::LENGTH_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_byte,
    input  logic            i_last_byte,
    input  logic [15:0]     i_payload_length,
    input  logic            i_full,
    output logic            o_push,
    output tcse_pkg::t_entry o_entry
);
    import tcse_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    // Sub-steps inside the server_name extension body.
    localparam logic [15:0] SNI_NAME_TYPE = 16'd2;
    localparam logic [15:0] SNI_LEN_HI    = 16'd3;
    localparam logic [15:0] SNI_LEN_LO    = 16'd4;

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_total, n_total;
    logic [15:0]            r_field, n_field;
    logic [15:0]            r_skip, n_skip;
    logic [LENGTH_BITS-1:0] r_ext_end, n_ext_end;
    logic [15:0]            r_name_rem, n_name_rem;
    logic [1:0]             r_flags, n_flags;

    logic accept;
    logic active;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    // A byte outside a payload is taken but ignored.
    assign active  = i_first_byte || (r_phase != PH_IDLE);

    // Next-state logic of the parser.
    always_comb begin
        t_phase                 c_phase;
        logic [LENGTH_BITS-1:0] p;
        logic [LENGTH_BITS-1:0] len;
        logic [15:0]            v;
        logic [SUM_BITS-1:0]    s;
        logic [15:0]            p16;
        logic [15:0]            ext16;

        // A first byte restarts from the reset state.
        if (i_first_byte) begin
            c_phase    = PH_HDR;
            p          = '0;
            len        = (i_payload_length > 16'(LEN_MAX)) ? LEN_MAX
                                                            : LENGTH_BITS'(i_payload_length);
            n_field    = '0;
            n_skip     = '0;
            n_ext_end  = '0;
            n_name_rem = '0;
            n_flags    = '0;
        end else begin
            c_phase    = r_phase;
            p          = r_pos;
            len        = r_total;
            n_field    = r_field;
            n_skip     = r_skip;
            n_ext_end  = r_ext_end;
            n_name_rem = r_name_rem;
            n_flags    = r_flags;
        end
        n_phase = c_phase;
        n_pos   = p;
        n_total = len;
        v       = '0;
        s       = '0;
        p16     = 16'(p);
        ext16   = 16'(n_ext_end);

        if (active) begin
            if (n_skip != '0) begin
                n_skip = n_skip - 16'd1;
            end else begin
                case (c_phase)
                    PH_HDR: begin
                        if ((p == LENGTH_BITS'(POS_REC_TYPE) &&
                             (i_data_byte != REC_HANDSHAKE ||
                              len <= LENGTH_BITS'(HDR_MIN_LEN))) ||
                            (p == LENGTH_BITS'(POS_VER_MAJOR) && i_data_byte != VER_MAJOR) ||
                            (p == LENGTH_BITS'(POS_HS_TYPE) && i_data_byte != HS_CLIENT_HELLO))
                        begin
                            n_phase = PH_DONE;
                        end else if (p >= LENGTH_BITS'(HDR_LAST_POS)) begin
                            n_phase = PH_SID;
                        end
                    end
                    PH_SID, PH_COMP: begin
                        s = SUM_BITS'(p) + SUM_BITS'(3) + SUM_BITS'(i_data_byte);
                        if (s >= SUM_BITS'(len)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = 16'(i_data_byte);
                            n_phase = (c_phase == PH_SID) ? PH_CS_HI : PH_ET_HI;
                        end
                    end
                    PH_CS_HI: begin
                        n_field = {i_data_byte, 8'h00};
                        n_phase = PH_CS_LO;
                    end
                    PH_CS_LO: begin
                        v = n_field | {8'h00, i_data_byte};
                        s = SUM_BITS'(p) + SUM_BITS'(2) + SUM_BITS'(v);
                        if (s >= SUM_BITS'(len)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = v;
                            n_phase = PH_COMP;
                        end
                    end
                    PH_ET_HI: begin
                        n_field = {i_data_byte, 8'h00};
                        n_phase = PH_ET_LO;
                    end
                    PH_ET_LO: begin
                        // Extension area, clipped to the payload length.
                        v = n_field | {8'h00, i_data_byte};
                        s = SUM_BITS'(p) + SUM_BITS'(1) + SUM_BITS'(v);
                        n_ext_end = (s > SUM_BITS'(len)) ? len : LENGTH_BITS'(s);
                        ext16     = 16'(n_ext_end);
                        n_phase   = ext_fits(p16, 16'd0, ext16) ? PH_X_T0 : PH_DONE;
                    end
                    PH_X_T0: begin
                        n_field = {i_data_byte, 8'h00};
                        n_phase = PH_X_T1;
                    end
                    PH_X_T1: begin
                        n_field = n_field | {8'h00, i_data_byte};
                        n_phase = PH_X_L0;
                    end
                    PH_X_L0: begin
                        n_name_rem = {i_data_byte, 8'h00};
                        n_phase    = PH_X_L1;
                    end
                    PH_X_L1: begin
                        v = n_name_rem | {8'h00, i_data_byte};
                        if (n_field == EXT_SERVER_NAME) begin
                            n_field    = v;
                            n_name_rem = '0;
                            n_phase    = PH_SNI;
                        end else if (ext_fits(p16, v, ext16)) begin
                            n_skip  = v;
                            n_phase = PH_X_T0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SNI: begin
                        if (p >= n_ext_end) begin
                            n_phase = PH_DONE;
                        end else if (n_name_rem < SNI_NAME_TYPE) begin
                            n_name_rem = n_name_rem + 16'd1;
                        end else if (n_name_rem == SNI_NAME_TYPE) begin
                            if (i_data_byte == NAME_HOST) begin
                                n_name_rem = SNI_LEN_HI;
                            end else begin
                                // Other name type: skip the rest of this extension.
                                v = (n_field >= 16'd3) ? (n_field - 16'd3) : 16'd0;
                                if (ext_fits(p16, v, ext16)) begin
                                    n_skip  = v;
                                    n_phase = PH_X_T0;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end else if (n_name_rem == SNI_LEN_HI) begin
                            n_field    = {i_data_byte, 8'h00};
                            n_name_rem = SNI_LEN_LO;
                        end else begin
                            v          = n_field | {8'h00, i_data_byte};
                            n_field    = v;
                            n_flags[1] = 1'b1;
                            s = SUM_BITS'(p) + SUM_BITS'(1) + SUM_BITS'(v);
                            if (v == 16'd0 || s > SUM_BITS'(n_ext_end)) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_name_rem = v;
                                n_phase    = PH_NAME;
                            end
                        end
                    end
                    PH_NAME: begin
                        if (n_name_rem != '0) begin
                            n_name_rem = n_name_rem - 16'd1;
                        end
                        if (n_name_rem == '0) begin
                            n_flags[0] = 1'b1;
                            n_phase    = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // The position counter saturates at the largest length.
            if (p != LEN_MAX) begin
                n_pos = p + LENGTH_BITS'(1);
            end
            if (i_last_byte) begin
                n_phase = PH_IDLE;
            end
        end else begin
            n_phase = r_phase;
        end
    end

    // Queue entry for the accepted byte.
    always_comb begin
        o_entry            = '0;
        o_entry.name_vld   = active && (i_first_byte ? 1'b0 : r_skip == '0) &&
                             !i_first_byte && r_phase == PH_NAME;
        o_entry.name_byte  = i_data_byte;
        o_entry.name_last  = (r_name_rem == 16'd1);
        o_entry.verd_vld   = active && i_last_byte;
        o_entry.verd_found = n_flags[0];
        o_entry.host_len   = n_flags[1] ? n_field : 16'd0;
        o_push             = accept && (o_entry.name_vld || o_entry.verd_vld);
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos      <= n_pos;
            r_total    <= n_total;
            r_field    <= n_field;
            r_skip     <= n_skip;
            r_ext_end  <= n_ext_end;
            r_name_rem <= n_name_rem;
            r_flags    <= n_flags;
        end
    end

    // While name characters stream, at least one is still owed.
    `TCSE_ASSERT_IMP(a_name_owed, r_phase == PH_NAME, r_name_rem != 16'd0, "name phase with no characters left")

endmodule

>>> sv/tcse_fifo.sv
// Short queue between the parser and the output side.
`include "tls_client_hello_sni_extractor_top_defines.svh"
module tcse_fifo #(
    parameter int DEPTH = tcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcse_pkg::t_entry i_entry,
    input  logic             i_pop,
    output tcse_pkg::t_entry o_head,
    output logic             o_empty,
    output logic             o_full
);
    import tcse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `TCSE_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(DEPTH), "queue occupancy beyond depth")
    `TCSE_ASSERT_IMP(a_no_overflow, i_push, !o_full, "push into a full queue")

endmodule

>>> sv/tcse_back.sv
// Back end: expands queue entries into result transactions.
`include "tls_client_hello_sni_extractor_top_defines.svh"
module tcse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcse_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_name_byte,
    output logic             o_name_last,
    output logic [15:0]      o_name_length,
    output logic             o_run_last
);
    import tcse_pkg::*;

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic [15:0] r_len, n_len;
    logic        r_run_last, n_run_last;
    logic        load;

    assign load = !r_valid || i_ready;

    // Pick the next result: the name character first, then the verdict.
    always_comb begin
        n_valid    = r_valid;
        n_sub      = r_sub;
        n_kind     = r_kind;
        n_byte     = r_byte;
        n_last     = r_last;
        n_len      = r_len;
        n_run_last = r_run_last;
        o_pop      = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.name_vld && !r_sub) begin
                    n_kind     = KIND_NAME;
                    n_byte     = i_head.name_byte;
                    n_last     = i_head.name_last;
                    n_len      = 16'd0;
                    n_run_last = !i_head.verd_vld;
                    n_sub      = i_head.verd_vld;
                    o_pop      = !i_head.verd_vld;
                end else begin
                    n_kind     = i_head.verd_found ? KIND_FOUND : KIND_NONE;
                    n_byte     = 8'h00;
                    n_last     = 1'b0;
                    n_len      = i_head.host_len;
                    n_run_last = 1'b1;
                    n_sub      = 1'b0;
                    o_pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_len      <= n_len;
        r_run_last <= n_run_last;
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_name_byte   = r_byte;
    assign o_name_last   = r_last;
    assign o_name_length = r_len;
    assign o_run_last    = r_run_last;

    // A half-sent entry stays at the queue head until its verdict goes out.
    `TCSE_ASSERT_IMP(a_sub_head, r_sub, !i_empty && i_head.name_vld && i_head.verd_vld, "verdict pending without a matching head entry")

endmodule

>>> sv/tls_client_hello_sni_extractor_top.sv
// A result passes through the queue and then the output register after its byte is accepted.
// One payload byte is taken per cycle while the queue is not full; a byte that yields a name
// character and the verdict gives two results, which the queue absorbs.
// The queue depth and the single output register set how long the output may stall.
// Reset (synchronous, active low) returns the parser to idle and empties the queue.
module tls_client_hello_sni_extractor_top #(
    parameter int LENGTH_BITS = tcse_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = tcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte [7:0], payload_length [23:8]
    input  logic        s_axis_tlast,   // last_byte
    input  logic [0:0]  s_axis_tuser,   // first_byte [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // name_byte [7:0], name_last [8], name_length [24:9]
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // result_kind [1:0]
);
    import tcse_pkg::*;

    t_entry      entry;
    t_entry      head;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    logic [7:0]  name_byte;
    logic        name_last;
    logic [15:0] name_length;

    // Parser front end.
    tcse_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_first_byte     (s_axis_tuser[0]),
        .i_last_byte      (s_axis_tlast),
        .i_payload_length (s_axis_tdata[23:8]),
        .i_full           (full),
        .o_push           (push),
        .o_entry          (entry)
    );

    // Queue between the two halves.
    tcse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Result output stage.
    tcse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (m_axis_tuser),
        .o_name_byte   (name_byte),
        .o_name_last   (name_last),
        .o_name_length (name_length),
        .o_run_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0000000, name_length, name_last, name_byte};

endmodule

>>> dv/tls_client_hello_sni_extractor_top_test.sv
// Self-checking testbench for the TLS ClientHello server-name extractor.
module tls_client_hello_sni_extractor_top_test;
    import tcse_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 4000000;
    localparam int PHASE_ITEMS    = 350;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POS_LIMIT      = (1 << LENGTH_BITS_DEF) - 1;
    localparam int FLAW_KINDS     = 9;

    // Ways in which a generated ClientHello departs from a clean one.
    typedef enum int {
        FLAW_NONE          = 0,
        FLAW_NAME_TYPE     = 1,
        FLAW_EMPTY_NAME    = 2,
        FLAW_NAME_TOO_LONG = 3,
        FLAW_NO_SNI        = 4,
        FLAW_TRUNCATE      = 5,
        FLAW_SHORT_EXT     = 6,
        FLAW_BAD_HEADER    = 7,
        FLAW_EXT_TOTAL     = 8
    } t_flaw;

    // One payload byte as offered on the input stream.
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] plen;
        logic        is_first;
        logic        is_last;
    } t_item;

    // One result as expected on the output stream.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic        name_last;
        logic [15:0] host_len;
        logic        run_last;
    } t_sni_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // data_byte [7:0], payload_length [23:8]
    logic        s_axis_tlast = 1'b0; // last_byte
    logic [0:0]  s_axis_tuser = '0;   // first_byte [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // name_byte [7:0], name_last [8], name_length [24:9]
    logic        m_axis_tlast;        // run_last
    logic [1:0]  m_axis_tuser;        // result_kind [1:0]

    // Pending input bytes, expected results and run bookkeeping.
    t_item       byte_queue[$];
    t_sni_result expected_results[$];
    logic [7:0]  pkt[$];
    int          accepted_cnt = 0;
    int          issued_cnt = 0;
    int          fail_cnt = 0;
    int          name_bytes_seen = 0;
    int          found_seen = 0;
    int          none_seen = 0;
    int          payloads_queued = 0;
    int          bytes_queued = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        rx_hold = 1'b0;

    // Predictor state.
    t_phase      ph = PH_IDLE;
    logic [15:0] pos = '0;
    logic [15:0] tot_len = '0;
    logic [15:0] fval = '0;
    logic [15:0] skip_cnt = '0;
    logic [15:0] ext_end = '0;
    logic [15:0] name_cnt = '0;
    logic [1:0]  flags = '0;

    tls_client_hello_sni_extractor_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Skip count bytes after position p, then expect another extension header if it fits.
    function automatic void advance_ext(input int unsigned p, input int unsigned count);
        if (p + 1 + count + 4 < ext_end) begin
            skip_cnt = 16'(count);
            ph = PH_X_T0;
        end else begin
            ph = PH_DONE;
        end
    endfunction

    // Advance the parser by one accepted byte and queue the results it causes.
    task automatic predict_sni(input logic [7:0] b, input logic first_b, input logic last_b,
                               input logic [15:0] plen);
        int unsigned p, len_total, v, e;
        if (first_b) begin
            ph = PH_HDR;
            pos = '0;
            tot_len = (plen > POS_LIMIT) ? 16'(POS_LIMIT) : plen;
            fval = '0;
            skip_cnt = '0;
            ext_end = '0;
            name_cnt = '0;
            flags = '0;
        end else if (ph == PH_IDLE) begin
            return;
        end
        p = pos;
        len_total = tot_len;

        if (skip_cnt != 0) begin
            skip_cnt = skip_cnt - 1'b1;
        end else begin
            case (ph)
                PH_HDR: begin
                    if ((p == POS_REC_TYPE && (b != REC_HANDSHAKE || len_total <= HDR_MIN_LEN)) ||
                        (p == POS_VER_MAJOR && b != VER_MAJOR) ||
                        (p == POS_HS_TYPE && b != HS_CLIENT_HELLO))
                        ph = PH_DONE;
                    else if (p >= HDR_LAST_POS)
                        ph = PH_SID;
                end
                PH_SID, PH_COMP: begin
                    if (p + 1 + b + 2 >= len_total) begin
                        ph = PH_DONE;
                    end else begin
                        skip_cnt = 16'(b);
                        ph = (ph == PH_SID) ? PH_CS_HI : PH_ET_HI;
                    end
                end
                PH_CS_HI: begin
                    fval = {b, 8'h00};
                    ph = PH_CS_LO;
                end
                PH_CS_LO: begin
                    v = 32'(fval) | 32'(b);
                    if (p + 1 + v + 1 >= len_total) begin
                        ph = PH_DONE;
                    end else begin
                        skip_cnt = 16'(v);
                        ph = PH_COMP;
                    end
                end
                PH_ET_HI: begin
                    fval = {b, 8'h00};
                    ph = PH_ET_LO;
                end
                PH_ET_LO: begin
                    // The extension area is clipped to the payload length.
                    v = 32'(fval) | 32'(b);
                    e = p + 1 + v;
                    if (e > len_total) e = len_total;
                    ext_end = 16'(e);
                    advance_ext(p, 0);
                end
                PH_X_T0: begin
                    fval = {b, 8'h00};
                    ph = PH_X_T1;
                end
                PH_X_T1: begin
                    fval = fval | {8'h00, b};
                    ph = PH_X_L0;
                end
                PH_X_L0: begin
                    name_cnt = {b, 8'h00};
                    ph = PH_X_L1;
                end
                PH_X_L1: begin
                    v = 32'(name_cnt) | 32'(b);
                    if (fval == EXT_SERVER_NAME) begin
                        fval = 16'(v);
                        name_cnt = '0;
                        ph = PH_SNI;
                    end else begin
                        advance_ext(p, v);
                    end
                end
                PH_SNI: begin
                    if (p >= ext_end) begin
                        ph = PH_DONE;
                    end else if (name_cnt < 2) begin
                        name_cnt = name_cnt + 1'b1;
                    end else if (name_cnt == 2) begin
                        // A name type other than host_name skips the rest of its extension.
                        if (b == NAME_HOST) begin
                            name_cnt = 16'd3;
                        end else begin
                            v = (fval >= 3) ? 32'(fval) - 3 : 0;
                            advance_ext(p, v);
                        end
                    end else if (name_cnt == 3) begin
                        fval = {b, 8'h00};
                        name_cnt = 16'd4;
                    end else begin
                        v = 32'(fval) | 32'(b);
                        fval = 16'(v);
                        flags[1] = 1'b1;
                        if (v == 0 || p + 1 + v > ext_end) begin
                            ph = PH_DONE;
                        end else begin
                            name_cnt = 16'(v);
                            ph = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    expected_results.push_back('{KIND_NAME, b, name_cnt == 16'd1, 16'd0,
                                                 !last_b});
                    if (name_cnt != 0) name_cnt = name_cnt - 1'b1;
                    if (name_cnt == 0) begin
                        flags[0] = 1'b1;
                        ph = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (pos < POS_LIMIT) pos = pos + 1'b1;

        if (last_b) begin
            expected_results.push_back('{flags[0] ? KIND_FOUND : KIND_NONE, 8'd0, 1'b0,
                                         flags[1] ? fval : 16'd0, 1'b1});
            ph = PH_IDLE;
        end
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic push16(input int value);
        pkt.push_back(8'(value >> 8));
        pkt.push_back(8'(value));
    endtask

    task automatic push_other_ext(input int ext_len);
        push16($urandom_range(1, 65535));
        push16(ext_len);
        repeat (ext_len) pkt.push_back(rnd_byte());
    endtask

    // Server-name list body: list length, name type, declared length, characters.
    task automatic push_name(input logic [7:0] ntype, input int declared, input int count);
        push16(count + 3);
        pkt.push_back(ntype);
        push16(declared);
        repeat (count) pkt.push_back(rnd_byte());
    endtask

    // Build a ClientHello in pkt, optionally with a padding extension ending at pad_to.
    task automatic build_hello(input int host_len, input t_flaw flaw, input int pad_to);
        int sid_len, cs_len, comp_len, ext_at, ext_len, keep, spot, name_end;
        if (flaw == FLAW_EMPTY_NAME) host_len = 0;
        pkt.delete();
        pkt.push_back(REC_HANDSHAKE);
        pkt.push_back(VER_MAJOR);
        repeat (3) pkt.push_back(rnd_byte());
        pkt.push_back(HS_CLIENT_HELLO);
        repeat (37) pkt.push_back(rnd_byte());

        sid_len = ($urandom_range(3) == 0) ? $urandom_range(32) : $urandom_range(2);
        pkt.push_back(8'(sid_len));
        repeat (sid_len) pkt.push_back(rnd_byte());
        cs_len = 2 * $urandom_range(1, 4);
        push16(cs_len);
        repeat (cs_len) pkt.push_back(rnd_byte());
        comp_len = $urandom_range(1, 2);
        pkt.push_back(8'(comp_len));
        repeat (comp_len) pkt.push_back(rnd_byte());

        ext_at = pkt.size();
        push16(0);
        if (pad_to > 0) begin
            ext_len = pad_to - (pkt.size() + 4);
            push16(16'h0015);
            push16(ext_len);
            repeat (ext_len) pkt.push_back(8'h00);
        end
        repeat ($urandom_range(2)) push_other_ext($urandom_range(6));
        if (flaw == FLAW_NAME_TYPE || flaw == FLAW_SHORT_EXT) begin
            push16(EXT_SERVER_NAME);
            push16((flaw == FLAW_SHORT_EXT) ? $urandom_range(2) : host_len + 5);
            push_name(8'($urandom_range(1, 255)), host_len, host_len);
        end
        if (flaw != FLAW_NO_SNI) begin
            push16(EXT_SERVER_NAME);
            push16(host_len + 5);
            push_name(NAME_HOST, (flaw == FLAW_NAME_TOO_LONG) ?
                      host_len + $urandom_range(1, 300) : host_len, host_len);
        end
        name_end = pkt.size();
        repeat ($urandom_range(1)) push_other_ext($urandom_range(6));

        ext_len = pkt.size() - ext_at - 2;
        if (flaw == FLAW_EXT_TOTAL) ext_len = $urandom_range(65535);
        pkt[ext_at]     = 8'(ext_len >> 8);
        pkt[ext_at + 1] = 8'(ext_len);

        if (flaw == FLAW_BAD_HEADER) begin
            case ($urandom_range(3))
                0:       spot = POS_REC_TYPE;
                1:       spot = POS_VER_MAJOR;
                2:       spot = POS_HS_TYPE;
                default: spot = $urandom_range(pkt.size() - 1);
            endcase
            pkt[spot] = pkt[spot] ^ 8'($urandom_range(1, 255));
        end
        if (flaw == FLAW_TRUNCATE) begin
            // Half the cuts land inside the name so that it ends part-way through.
            if ($urandom_range(1) && host_len > 0)
                keep = name_end - $urandom_range(1, host_len);
            else
                keep = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
    endtask

    task automatic queue_item(input logic [7:0] data, input logic first_b, input logic last_b,
                              input logic [15:0] plen);
        byte_queue.push_back('{data, plen, first_b, last_b});
        bytes_queued++;
    endtask

    // Queue pkt as one payload; the length field is only meaningful on the first byte.
    task automatic queue_payload(input logic [15:0] plen, input bit with_end);
        foreach (pkt[i])
            queue_item(pkt[i], i == 0, with_end && (i == pkt.size() - 1),
                       (i == 0) ? plen : 16'($urandom_range(65535)));
        payloads_queued++;
    endtask

    // Driver: offers the next pending byte once the current transaction has completed.
    always @(negedge i_clk) begin : stream_driver
        t_item it;
        if (i_rst_n && accepted_cnt == issued_cnt) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = byte_queue.pop_front();
                s_axis_tdata  <= {it.plen, it.data};
                s_axis_tlast  <= it.is_last;
                s_axis_tuser  <= it.is_first;
                s_axis_tvalid <= 1'b1;
                issued_cnt++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts each accepted byte and checks each accepted result in order.
    always @(posedge i_clk) begin : result_monitor
        t_sni_result want;
        logic [31:0] want_data;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sni(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tlast,
                            s_axis_tdata[23:8]);
                accepted_cnt++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: kind %0d tdata %h tlast %b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_results.pop_front();
                    want_data = {7'd0, want.host_len, want.name_last, want.name_byte};
                    if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data ||
                        m_axis_tlast !== want.run_last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch: want kind %0d byte %h last %b len %0d run %b,",
                                      " got kind %0d tdata %h run %b"},
                                     want.kind, want.name_byte, want.name_last, want.host_len,
                                     want.run_last, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                    if (want.kind == KIND_NAME) name_bytes_seen++;
                    else if (want.kind == KIND_FOUND) found_seen++;
                    else none_seen++;
                end
            end
        end
    end

    // Long receiver hold-off once names are flowing, so that the output queue backs up.
    initial begin : receiver_hold
        wait (name_bytes_seen >= 2);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : run_limit
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus: directed payloads, then random ClientHellos and noise under four idling modes.
    initial begin : stimulus
        int phase_no, phase_items, pick, host_len, short_len, flaw_tour;
        t_flaw flaw;
        logic [15:0] plen;
        flaw_tour = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 65; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase

            if (phase_no == 0) begin
                // Bytes with no payload open are ignored, even with last_byte set.
                queue_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);
                queue_item(8'h00, 1'b0, 1'b0, 16'h0000);
                // One-byte payloads at both length extremes.
                pkt = '{REC_HANDSHAKE};
                queue_payload(16'hFFFF, 1'b1);
                pkt = '{8'h00};
                queue_payload(16'h0000, 1'b1);
                // Payload too short to hold a ClientHello.
                pkt = '{REC_HANDSHAKE, VER_MAJOR, 8'hFF};
                queue_payload(16'd43, 1'b1);
                // Wrong major version, then wrong handshake type.
                pkt = '{REC_HANDSHAKE, VER_MAJOR + 8'd1, 8'h01};
                queue_payload(16'd200, 1'b1);
                pkt = '{REC_HANDSHAKE, VER_MAJOR, 8'h03, 8'h00, 8'h40, HS_CLIENT_HELLO + 8'd1};
                queue_payload(16'd300, 1'b1);
                // Left open: the next payload starts mid-stream.
                pkt = '{REC_HANDSHAKE, VER_MAJOR};
                queue_payload(16'd120, 1'b0);
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    if (flaw_tour < FLAW_KINDS) begin
                        flaw = t_flaw'(flaw_tour);
                        flaw_tour++;
                    end else if ($urandom_range(1)) begin
                        flaw = FLAW_NONE;
                    end else begin
                        flaw = t_flaw'($urandom_range(1, FLAW_KINDS - 1));
                    end
                    host_len = ($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                        : $urandom_range(1, 10);
                    build_hello(host_len, flaw, 0);
                    if ($urandom_range(4) == 0)
                        repeat ($urandom_range(1, 4)) pkt.push_back(rnd_byte());
                    plen = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                    : 16'(pkt.size());
                    queue_payload(plen, !(flaw == FLAW_TRUNCATE && $urandom_range(1)));
                    phase_items += pkt.size();
                end else if (pick < 70) begin
                    repeat ($urandom_range(1, 3))
                        queue_item(rnd_byte(), 1'b0, 1'($urandom_range(1)),
                                   16'($urandom_range(65535)));
                end else begin
                    pkt.delete();
                    short_len = $urandom_range(1, 48);
                    repeat (short_len) pkt.push_back(rnd_byte());
                    if ($urandom_range(1)) pkt[0] = REC_HANDSHAKE;
                    if (short_len > 1 && $urandom_range(1)) pkt[1] = VER_MAJOR;
                    plen = $urandom_range(1) ? 16'(short_len) : 16'($urandom_range(65535));
                    queue_payload(plen, $urandom_range(5) != 0);
                    phase_items += short_len;
                end
            end

            while (!(byte_queue.size() == 0 && accepted_cnt == issued_cnt)) @(posedge i_clk);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_cnt += expected_results.size();

        $display("Sent %0d bytes in %0d payloads under four idling modes and a long hold-off.",
                 bytes_queued, payloads_queued);
        $display("Checked %0d name bytes, %0d found and %0d no-name verdicts; %0d mismatches.",
                 name_bytes_seen, found_seen, none_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/tcse_pkg.sv
sv/tcse_front.sv
sv/tcse_fifo.sv
sv/tcse_back.sv
sv/tls_client_hello_sni_extractor_top.sv
dv/tls_client_hello_sni_extractor_top_test.sv
